/* design/arrt_pkg.sv */
// shared types, codes and constants for the address rewrite route table
`default_nettype none

package arrt_pkg;

  // table geometry defaults
  localparam int BUCKET_BITS_DEF = 10;
  localparam int WAYS_DEF        = 4;

  // field widths
  localparam int ADDR_W  = 32;
  localparam int IDENT_W = 16;
  localparam int TTL_W   = 8;
  localparam int ETYPE_W = 16;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  // one table entry: {valid, key, value}
  localparam int ENT_W = 1 + 2 * ADDR_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_VALID   = 1'b1;

  // hashing and rewrite constants
  localparam logic [ADDR_W-1:0]  HASH_MULT   = 32'h61C8_8647;
  localparam logic [ADDR_W-1:0]  NET_MASK    = 32'hFFFF_FFE0;
  localparam logic [ADDR_W-1:0]  OCTET_CLEAR = 32'hFFFF_FF00;
  localparam logic [ADDR_W-1:0]  REWRITE_MASK = NET_MASK & OCTET_CLEAR;
  localparam logic [TTL_W-1:0]   ENC_TTL_BIT = 8'h80;
  localparam logic [ETYPE_W-1:0] ETH_IPV4    = 16'h0800;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REWRITE = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_PASS      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL
  } fsm_t;

  // set compare summary handed from the set evaluator to the control
  typedef struct packed {
    logic hit;
    logic has_free;
  } match_t;

endpackage

`default_nettype wire

/* design/arrt_if.sv */
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface arrt_in_if;
  import arrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [ADDR_W-1:0]  key_address;
  logic [ADDR_W-1:0]  mapped_address;
  logic [ADDR_W-1:0]  packet_dest;
  logic [IDENT_W-1:0] packet_ident;
  logic [TTL_W-1:0]   packet_ttl;
  logic [ETYPE_W-1:0] frame_ethertype;

  modport source (output valid, opcode, key_address, mapped_address, packet_dest,
                  packet_ident, packet_ttl, frame_ethertype, input ready);
  modport sink   (input valid, opcode, key_address, mapped_address, packet_dest,
                  packet_ident, packet_ttl, frame_ethertype, output ready);
endinterface

interface arrt_out_if;
  import arrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] new_source;
  logic [ADDR_W-1:0] new_dest;

  modport source (output valid, status, new_source, new_dest, input ready);
  modport sink   (input valid, status, new_source, new_dest, output ready);
endinterface

`default_nettype wire

/* design/arrt_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module arrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/arrt_set_eval.sv */
// compares all ways of one set and builds the write-back row
`default_nettype none

module arrt_set_eval
  import arrt_pkg::*;
#(
  parameter int WAYS = WAYS_DEF
) (
  input  wire logic [WAYS*ENT_W-1:0] row,
  input  wire logic [ADDR_W-1:0]     key,
  input  wire logic [ADDR_W-1:0]     mapped,
  input  wire logic                  is_add,
  output      match_t                match,
  output      logic [ADDR_W-1:0]     hit_value,
  output      logic [WAYS*ENT_W-1:0] wb_row
);

  logic [WAYS-1:0] valid;
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic [WAYS-1:0] first_free;

  // per-way compare
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid[w]   = row[w*ENT_W + 2*ADDR_W];
      hit_vec[w] = valid[w] && (row[w*ENT_W + ADDR_W +: ADDR_W] == key);
    end
  end

  // lowest free way as a one-hot
  assign free_vec   = ~valid;
  assign first_free = free_vec & (~free_vec + WAYS'(1));

  assign match.hit      = |hit_vec;
  assign match.has_free = |free_vec;

  // value of the hitting way (keys are unique within a set)
  always_comb begin
    hit_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_value = hit_value | (row[w*ENT_W +: ADDR_W] & {ADDR_W{hit_vec[w]}});
    end
  end

  // insert into the first free way, or drop the valid bit of the hit
  always_comb begin
    wb_row = row;
    for (int w = 0; w < WAYS; w++) begin
      if (is_add) begin
        if (first_free[w]) begin
          wb_row[w*ENT_W +: ENT_W] = {1'b1, key, mapped};
        end
      end else begin
        if (hit_vec[w]) begin
          wb_row[w*ENT_W + 2*ADDR_W] = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/address_rewrite_route_table_core.sv */
// top level: set-associative route table with received-header address rewrite
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        opcode, key, mapped, dest, ident, ttl, ethertype
//  out_ch    out  valid/ready        status, new_source, new_dest
//  cfg_*     in   write enable only  index, 32-bit data
//
//  an item steps through accept, hash multiply, set read, compare and write back;
//  the one-item sequencer takes no new item until the last one has left compare
//  after reset a clearing pass writes every set with in_ch held not ready;
//  configuration writes are taken during it
//  a result waits in the output register while the next item is accepted; the
//  compare stage stalls only while a previous result is still untaken
`default_nettype none

module address_rewrite_route_table_core
  import arrt_pkg::*;
#(
  parameter int BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int WAYS        = WAYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  arrt_in_if.sink                    in_ch,
  arrt_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SETS  = 1 << BUCKET_BITS;
  localparam int ROW_W = WAYS * ENT_W;

  fsm_t state_r, state_nxt;

  logic [BUCKET_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [BUCKET_BITS-1:0] set_r;
  logic                   clr_last;

  // item registers
  logic [OP_W-1:0]    op_r;
  logic [ADDR_W-1:0]  key_r;
  logic [ADDR_W-1:0]  mapped_r;
  logic [ADDR_W-1:0]  dest_r;
  logic [IDENT_W-1:0] ident_r;
  logic [TTL_W-1:0]   ttl_r;
  logic [ETYPE_W-1:0] etype_r;

  // configuration
  logic [ADDR_W-1:0] local_addr_r;
  logic              local_valid_r;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r;
  logic [ADDR_W-1:0] new_source_r;
  logic [ADDR_W-1:0] new_dest_r;

  // ram control
  logic                   ram_we;
  logic [BUCKET_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [ROW_W-1:0]       ram_rdata;

  logic [ADDR_W-1:0] product;
  logic              in_ready;
  logic              in_fire;
  logic              eval_go;
  logic              load_out;

  match_t            match;
  logic [ADDR_W-1:0] hit_value;
  logic [ROW_W-1:0]  wb_row;
  logic              is_add;
  logic              qualified;
  logic              tbl_write;
  logic [ADDR_W-1:0] dbase;

  status_t           res_status;
  logic [ADDR_W-1:0] res_source;
  logic [ADDR_W-1:0] res_dest;

  assign in_fire   = in_ch.valid && in_ready;
  assign eval_go   = !out_valid_r || out_ch.ready;
  assign clr_last  = (clr_cnt_r == {BUCKET_BITS{1'b1}});
  assign is_add    = (op_r == OP_ADD);
  assign qualified = (op_r == OP_REWRITE) && (etype_r == ETH_IPV4) &&
                     ((ttl_r & ENC_TTL_BIT) != '0);
  assign dbase     = local_valid_r ? local_addr_r : dest_r;

  // fibonacci hash multiply, registered as the set index
  assign product = key_r * HASH_MULT;

  // table ram, one row per set
  arrt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (set_r),
    .rdata (ram_rdata)
  );

  arrt_set_eval #(
    .WAYS (WAYS)
  ) u_set_eval (
    .row       (ram_rdata),
    .key       (key_r),
    .mapped    (mapped_r),
    .is_add    (is_add),
    .match     (match),
    .hit_value (hit_value),
    .wb_row    (wb_row)
  );

  // result and table update decision
  always_comb begin
    res_status = ST_PASS;
    res_source = '0;
    res_dest   = '0;
    tbl_write  = 1'b0;
    case (op_r)
      OP_ADD: begin
        if (match.hit) begin
          res_status = ST_EXISTS;
        end else if (match.has_free) begin
          res_status = ST_DONE;
          tbl_write  = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (match.hit) begin
          res_status = ST_DONE;
          tbl_write  = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_source = key_r;
        res_dest   = dest_r;
        if (qualified && match.hit) begin
          res_status = ST_DONE;
          res_source = (hit_value & REWRITE_MASK) | ADDR_W'(ident_r[15:8]);
          res_dest   = (dbase & REWRITE_MASK) | ADDR_W'(ident_r[7:0]);
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_ch.valid) state_nxt = S_HASH;
      S_HASH:  state_nxt = S_READ;
      S_READ:  state_nxt = S_EVAL;
      S_EVAL:  if (eval_go) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = wb_row;
    load_out  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE: in_ready = 1'b1;
      S_READ: ram_re = 1'b1;
      S_EVAL: begin
        load_out = eval_go;
        ram_we   = eval_go && tbl_write;
      end
      default: ;
    endcase
  end

  assign clr_cnt_nxt   = clr_cnt_r + BUCKET_BITS'(1);
  assign out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      local_valid_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS: local_addr_r  <= cfg_data[ADDR_W-1:0];
        CFG_LOCAL_VALID:   local_valid_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item capture and set index
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_ch.opcode;
      key_r    <= in_ch.key_address;
      mapped_r <= in_ch.mapped_address;
      dest_r   <= in_ch.packet_dest;
      ident_r  <= in_ch.packet_ident;
      ttl_r    <= in_ch.packet_ttl;
      etype_r  <= in_ch.frame_ethertype;
    end
    if (state_r == S_HASH) begin
      set_r <= product[ADDR_W-1 -: BUCKET_BITS];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r     <= res_status;
      new_source_r <= res_source;
      new_dest_r   <= res_dest;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.new_source = new_source_r;
  assign out_ch.new_dest   = new_dest_r;

  // table writes only come from the clearing pass or a successful add/delete
  a_we_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR) ||
               (state_r == S_EVAL && res_status == ST_DONE &&
                (op_r == OP_ADD || op_r == OP_DELETE)))
    else $error("table write outside clear or successful update");

  // clearing pass ends in idle
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_last) |=> (state_r == S_IDLE))
    else $error("clearing pass did not hand over to idle");

  // every finished item leaves a result in the output register
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (status_r == $past(res_status)))
    else $error("finished item produced no result");

  // no item is accepted during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

endmodule

`default_nettype wire
